[src/ipatp_pkg.sv]
// ipatp_pkg: types, character codes and per-character parse functions
// for the ip address text parser; depends on nothing else
`default_nettype none

package ipatp_pkg;

  localparam int unsigned NumGroups = 8;
  localparam int unsigned GroupW    = 16;
  localparam int unsigned GcntW     = 4;  // holds 0..8 groups
  localparam int unsigned HcntW     = 3;  // holds 0..4 hex digits
  localparam int unsigned OcntW     = 3;  // holds 0..4 octets
  localparam int unsigned AddrW     = 64;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] LowBias = 8'h57;  // 'a' - 10
  localparam logic [7:0] UpBias  = 8'h37;  // 'A' - 10

  localparam logic [11:0] OctetMax = 12'd255;

  typedef enum logic [2:0] {
    PH_START,
    PH_V4,
    PH_V6_LEAD,
    PH_V6,
    PH_V6_TAIL,
    PH_ERR
  } phase_e;

  typedef logic [NumGroups-1:0][GroupW-1:0] groups_t;

  // per-string parser state
  typedef struct packed {
    phase_e            phase;
    groups_t           groups;
    logic [GcntW-1:0]  gcnt;
    logic [GcntW-1:0]  gpos;
    logic              gap;
    logic [GroupW-1:0] acc;
    logic [HcntW-1:0]  hcnt;
    logic [7:0]        tok;
    logic              tok_ok;
    logic [7:0]        oct;
    logic [OcntW-1:0]  ocnt;
    logic              oct_seen;
    logic [31:0]       quad;
  } pstate_t;

  // snapshot handed from the parse stage to the finish stage
  typedef struct packed {
    logic             is_v4;
    logic             ok;
    groups_t          groups;
    logic [GcntW-1:0] gcnt;
    logic [GcntW-1:0] gpos;
    logic             gap;
    logic [31:0]      quad;
  } finish_t;

  function automatic pstate_t init_state();
    pstate_t s;
    s          = '0;
    s.phase    = PH_START;
    s.tok_ok   = 1'b1;
    return s;
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  // {legal, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] v;
    logic       hit;
    v   = '0;
    hit = 1'b1;
    if (is_dec(c)) begin
      v = c - ChZero;
    end else if ((c >= ChLowA) && (c <= ChLowF)) begin
      v = c - LowBias;
    end else if ((c >= ChUpA) && (c <= ChUpF)) begin
      v = c - UpBias;
    end else begin
      hit = 1'b0;
    end
    return {hit, v[3:0]};
  endfunction

  // x * 10 + digit
  function automatic logic [11:0] dec_push(input logic [7:0] x, input logic [7:0] c);
    logic [11:0] xw;
    logic [7:0]  d;
    xw = {4'b0, x};
    d  = c - ChZero;
    return (xw << 3) + (xw << 1) + {8'b0, d[3:0]};
  endfunction

  function automatic pstate_t dotted_char(input pstate_t st, input logic [7:0] c);
    pstate_t     s;
    logic [11:0] v;
    s = st;
    v = dec_push(st.oct, c);
    if (is_dec(c)) begin
      if ((st.oct_seen && (st.oct == 8'd0)) || (v > OctetMax)) begin
        s.phase = PH_ERR;
      end else begin
        s.oct = v[7:0];
        if (!st.oct_seen) begin
          if (st.ocnt >= OcntW'(4)) begin
            s.phase = PH_ERR;
          end else begin
            s.ocnt     = st.ocnt + OcntW'(1);
            s.oct_seen = 1'b1;
          end
        end
      end
    end else if ((c == ChDot) && st.oct_seen) begin
      if (st.ocnt >= OcntW'(4)) begin
        s.phase = PH_ERR;
      end else begin
        s.quad     = {st.quad[23:0], st.oct};
        s.oct      = '0;
        s.oct_seen = 1'b0;
      end
    end else begin
      s.phase = PH_ERR;
    end
    return s;
  endfunction

  function automatic pstate_t v6_char(input pstate_t st, input logic [7:0] c,
                                      input logic is_last);
    pstate_t     s;
    logic [4:0]  h;
    logic [11:0] v;
    s = st;
    h = hex_decode(c);
    v = dec_push(st.tok, c);
    if (h[4]) begin
      if (is_dec(c) && st.tok_ok) begin
        if (((st.hcnt != '0) && (st.tok == 8'd0)) || (v > OctetMax)) begin
          s.tok_ok = 1'b0;
        end else begin
          s.tok = v[7:0];
        end
      end else if (!is_dec(c)) begin
        s.tok_ok = 1'b0;
      end
      if (st.hcnt >= HcntW'(4)) begin
        s.phase = PH_ERR;
      end else begin
        s.acc  = {st.acc[GroupW-5:0], h[3:0]};
        s.hcnt = st.hcnt + HcntW'(1);
      end
    end else if (c == ChColon) begin
      if (st.hcnt == '0) begin
        if (st.gap) begin
          s.phase = PH_ERR;
        end else begin
          s.gap  = 1'b1;
          s.gpos = st.gcnt;
        end
      end else begin
        if (is_last || (st.gcnt >= GcntW'(NumGroups))) begin
          s.phase = PH_ERR;
        end else begin
          s.groups[st.gcnt[2:0]] = st.acc;
          s.gcnt = st.gcnt + GcntW'(1);
          s.acc  = '0;
          s.hcnt = '0;
        end
      end
      s.tok    = '0;
      s.tok_ok = 1'b1;
    end else if ((c == ChDot) && (st.hcnt != '0) && st.tok_ok &&
                 (st.gcnt <= GcntW'(6))) begin
      s.quad     = {24'b0, st.tok};
      s.oct      = '0;
      s.oct_seen = 1'b0;
      s.ocnt     = OcntW'(1);
      s.acc      = '0;
      s.hcnt     = '0;
      s.phase    = PH_V6_TAIL;
    end else begin
      s.phase = PH_ERR;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

[src/ip_address_text_parser.sv]
// Takes one address character per cycle, when not stalled, and streams through.
// The parse state is updated in the cycle a character is accepted, so a new
// character can be taken every cycle; this state loop sets the rate.
// On the character marked tlast the parsed groups are captured into a finish
// stage that places groups around a '::' gap, and the result (valid flag and
// 128-bit address) is then registered in the output register. Stalls on the
// output side hold the finish stage and then the input.
// ip_address_text_parser: top level; depends on ipatp_pkg
`default_nettype none

module ip_address_text_parser (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [7:0]   s_axis_tdata_i,   // [7:0] ch
  input  wire logic         s_axis_tuser_i,   // [0] family
  input  wire logic         s_axis_tlast_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [127:0]      m_axis_tdata_o,   // [63:0] addr_high, [127:64] addr_low
  output logic              m_axis_tuser_o    // [0] valid_res
);

  localparam int unsigned NG = ipatp_pkg::NumGroups;

  ipatp_pkg::pstate_t st_q, st_d, st_step;
  ipatp_pkg::finish_t fin_q, fin_d;
  logic               fin_vld_q;
  logic               out_vld_q;
  logic               out_ok_q;
  logic [ipatp_pkg::AddrW-1:0] out_hi_q, out_lo_q;
  logic               out_ok_d;
  logic [ipatp_pkg::AddrW-1:0] out_hi_d, out_lo_d;
  logic               out_load, fin_ready, accept;

  assign out_load        = !out_vld_q || m_axis_tready_i;
  assign fin_ready       = !fin_vld_q || out_load;
  assign s_axis_tready_o = fin_ready;
  assign accept          = s_axis_tvalid_i && fin_ready;

  // per-character parse step
  always_comb begin
    st_step = st_q;
    case (st_q.phase)
      ipatp_pkg::PH_START: begin
        if (!s_axis_tuser_i) begin
          st_step.phase = ipatp_pkg::PH_V4;
          st_step = ipatp_pkg::dotted_char(st_step, s_axis_tdata_i);
        end else if (s_axis_tdata_i == ipatp_pkg::ChColon) begin
          st_step.phase = ipatp_pkg::PH_V6_LEAD;
        end else begin
          st_step.phase = ipatp_pkg::PH_V6;
          st_step = ipatp_pkg::v6_char(st_step, s_axis_tdata_i, s_axis_tlast_i);
        end
      end
      ipatp_pkg::PH_V4, ipatp_pkg::PH_V6_TAIL: begin
        st_step = ipatp_pkg::dotted_char(st_q, s_axis_tdata_i);
      end
      ipatp_pkg::PH_V6_LEAD: begin
        if (s_axis_tdata_i == ipatp_pkg::ChColon) begin
          st_step.phase = ipatp_pkg::PH_V6;
          st_step = ipatp_pkg::v6_char(st_step, s_axis_tdata_i, s_axis_tlast_i);
        end else begin
          st_step.phase = ipatp_pkg::PH_ERR;
        end
      end
      ipatp_pkg::PH_V6: begin
        st_step = ipatp_pkg::v6_char(st_q, s_axis_tdata_i, s_axis_tlast_i);
      end
      default: begin
        st_step = st_q;
      end
    endcase
  end

  assign st_d = s_axis_tlast_i ? ipatp_pkg::init_state() : st_step;

  // close the string: flush the open group or the dotted tail
  always_comb begin
    logic [31:0] q;
    q            = {st_step.quad[23:0], st_step.oct};
    fin_d        = '0;
    fin_d.groups = st_step.groups;
    fin_d.gcnt   = st_step.gcnt;
    fin_d.gpos   = st_step.gpos;
    fin_d.gap    = st_step.gap;
    fin_d.quad   = q;
    case (st_step.phase)
      ipatp_pkg::PH_V4: begin
        fin_d.is_v4 = 1'b1;
        fin_d.ok    = (st_step.ocnt == ipatp_pkg::OcntW'(4));
      end
      ipatp_pkg::PH_V6: begin
        fin_d.ok = 1'b1;
        if (st_step.hcnt != '0) begin
          if (st_step.gcnt >= ipatp_pkg::GcntW'(NG)) begin
            fin_d.ok = 1'b0;
          end else begin
            fin_d.groups[st_step.gcnt[2:0]] = st_step.acc;
            fin_d.gcnt = st_step.gcnt + ipatp_pkg::GcntW'(1);
          end
        end
      end
      ipatp_pkg::PH_V6_TAIL: begin
        if ((st_step.ocnt == ipatp_pkg::OcntW'(4)) &&
            (st_step.gcnt <= ipatp_pkg::GcntW'(6))) begin
          fin_d.ok = 1'b1;
          fin_d.groups[st_step.gcnt[2:0]] = q[31:16];
          fin_d.groups[3'(st_step.gcnt[2:0] + 3'd1)] = q[15:0];
          fin_d.gcnt = st_step.gcnt + ipatp_pkg::GcntW'(2);
        end
      end
      default: begin
        fin_d.ok = 1'b0;
      end
    endcase
  end

  // finish stage: gap check and zero fill
  always_comb begin
    ipatp_pkg::groups_t fin;
    logic [4:0] span;
    logic       ok;
    fin  = '0;
    span = '0;
    ok   = fin_q.ok;
    if (fin_q.is_v4) begin
      out_hi_d = '0;
      out_lo_d = {32'b0, fin_q.quad};
    end else begin
      if (fin_q.gap) begin
        ok = ok && (fin_q.gcnt < ipatp_pkg::GcntW'(NG)) && (fin_q.gpos <= fin_q.gcnt);
        for (int j = 0; j < NG; j++) begin
          // j + (groups after the gap) reaching 8 means a tail group lands here
          span = 5'(j) + {1'b0, fin_q.gcnt} - {1'b0, fin_q.gpos};
          if (4'(j) < fin_q.gpos) begin
            fin[j] = fin_q.groups[j];
          end else if (span >= 5'(NG)) begin
            fin[j] = fin_q.groups[3'(3'(j) + fin_q.gcnt[2:0])];
          end else begin
            fin[j] = '0;
          end
        end
      end else begin
        ok  = ok && (fin_q.gcnt == ipatp_pkg::GcntW'(NG));
        fin = fin_q.groups;
      end
      out_hi_d = {fin[0], fin[1], fin[2], fin[3]};
      out_lo_d = {fin[4], fin[5], fin[6], fin[7]};
    end
    out_ok_d = ok;
    if (!ok) begin
      out_hi_d = '0;
      out_lo_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ipatp_pkg::init_state();
      fin_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        st_q <= st_d;
      end
      if (fin_ready) begin
        fin_vld_q <= accept && s_axis_tlast_i;
      end
      if (out_load) begin
        out_vld_q <= fin_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_ready && accept && s_axis_tlast_i) begin
      fin_q <= fin_d;
    end
    if (out_load && fin_vld_q) begin
      out_ok_q <= out_ok_d;
      out_hi_q <= out_hi_d;
      out_lo_q <= out_lo_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_ok_q;
  assign m_axis_tdata_o  = {out_lo_q, out_hi_q};

endmodule

`default_nettype wire
